@@ rtl/brmc_pkg.sv @@
// Shared types, constants and decode functions of the banked register and mode control block.
package brmc_pkg;

   localparam int unsigned BANKED_PER_MODE = 7;
   localparam int unsigned NUM_BANKS       = 6;
   localparam int unsigned BANK_ENTRIES    = BANKED_PER_MODE * NUM_BANKS;
   localparam int unsigned BANK_AW         = $clog2(BANK_ENTRIES);

   localparam logic [2:0] SLOT_R13 = 3'(BANKED_PER_MODE - 2);
   localparam logic [2:0] SLOT_R14 = 3'(BANKED_PER_MODE - 1);

   localparam logic [2:0] USR_BANK = 3'd0;
   localparam logic [2:0] FIQ_BANK = 3'd1;
   localparam logic [2:0] IRQ_BANK = 3'd2;
   localparam logic [2:0] SVC_BANK = 3'd3;
   localparam logic [2:0] ABT_BANK = 3'd4;
   localparam logic [2:0] UND_BANK = 3'd5;

   localparam logic [4:0] USR_MODE = 5'h10;
   localparam logic [4:0] FIQ_MODE = 5'h11;
   localparam logic [4:0] IRQ_MODE = 5'h12;
   localparam logic [4:0] SVC_MODE = 5'h13;
   localparam logic [4:0] ABT_MODE = 5'h17;
   localparam logic [4:0] UND_MODE = 5'h1B;
   localparam logic [4:0] SYS_MODE = 5'h1F;

   localparam int unsigned BIT_THUMB = 5;
   localparam int unsigned BIT_IMASK = 7;

   localparam logic [31:0] VEC_IRQ        = 32'h18;
   localparam logic [31:0] PC_AHEAD       = 32'd8;
   localparam logic [31:0] ARM_RET_OFFSET = 32'd4;
   localparam logic [31:0] STATUS_RESET   = {27'd0, SYS_MODE};

   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_STATUS = 3'd2,
      OP_SWITCH = 3'd3,
      OP_IRQ    = 3'd4,
      OP_COND   = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
      CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
   } cond_type;

   function automatic logic mode_valid(input logic [4:0] mode);
      case (mode)
         USR_MODE, SYS_MODE, FIQ_MODE, IRQ_MODE,
         SVC_MODE, ABT_MODE, UND_MODE: mode_valid = 1'b1;
         default:                      mode_valid = 1'b0;
      endcase
   endfunction

   // Invalid codes fall back to the user bank.
   function automatic logic [2:0] mode_bank(input logic [4:0] mode);
      case (mode)
         FIQ_MODE: mode_bank = FIQ_BANK;
         IRQ_MODE: mode_bank = IRQ_BANK;
         SVC_MODE: mode_bank = SVC_BANK;
         ABT_MODE: mode_bank = ABT_BANK;
         UND_MODE: mode_bank = UND_BANK;
         default:  mode_bank = USR_BANK;
      endcase
   endfunction

   function automatic logic [BANK_AW-1:0] bank_base(input logic [2:0] bank);
      case (bank)
         FIQ_BANK: bank_base = BANK_AW'(1 * BANKED_PER_MODE);
         IRQ_BANK: bank_base = BANK_AW'(2 * BANKED_PER_MODE);
         SVC_BANK: bank_base = BANK_AW'(3 * BANKED_PER_MODE);
         ABT_BANK: bank_base = BANK_AW'(4 * BANKED_PER_MODE);
         UND_BANK: bank_base = BANK_AW'(5 * BANKED_PER_MODE);
         default:  bank_base = '0;
      endcase
   endfunction

   // Flags are N, Z, C, V from bit 3 down to bit 0.
   function automatic logic cond_holds(input logic [3:0] flags, input logic [3:0] cond);
      logic n, z, c, v;
      n = flags[3];
      z = flags[2];
      c = flags[1];
      v = flags[0];
      case (cond_type'(cond))
         CC_EQ:   cond_holds = z;
         CC_NE:   cond_holds = !z;
         CC_CS:   cond_holds = c;
         CC_CC:   cond_holds = !c;
         CC_MI:   cond_holds = n;
         CC_PL:   cond_holds = !n;
         CC_VS:   cond_holds = v;
         CC_VC:   cond_holds = !v;
         CC_HI:   cond_holds = c && !z;
         CC_LS:   cond_holds = !c || z;
         CC_GE:   cond_holds = (n == v);
         CC_LT:   cond_holds = (n != v);
         CC_GT:   cond_holds = !(z || (n != v));
         CC_LE:   cond_holds = z || (n != v);
         default: cond_holds = 1'b1;
      endcase
   endfunction

endpackage

@@ rtl/banked_register_mode_control.sv @@
// Register file with mode banks, status word and IRQ entry sequencer.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the response strobe rsp_valid, which lasts one cycle and cannot be held
// off, so the receiver must take it when it appears. Reads, writes, status
// writes, condition checks, masked IRQs, invalid mode codes and switches that
// keep the bank answer through the decode and response states. A switch between
// banks moves banked registers through the single read and single write port of
// the bank memory, a read state and a write state per register: r13 and r14
// alone, or r8 to r14 for a switch into or out of FIQ mode. A taken IRQ then
// passes through the link register and program counter states. The exception
// base register may be written only while no request is in flight.
module banked_register_mode_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_reg_index,
   input  logic [31:0] req_data,
   input  logic [4:0]  req_mode_value,
   input  logic [3:0]  req_cond,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_cond_passed,
   output logic        rsp_irq_taken,
   output logic        rsp_bad_mode,
   output logic [31:0] rsp_status_word,
   output logic [31:0] rsp_saved_status,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   localparam int unsigned AW = brmc_pkg::BANK_AW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_IRQ_LR,
      ST_IRQ_PC,
      ST_RESP
   } state_type;

   state_type        state_ff;
   brmc_pkg::op_type op_ff;
   logic [3:0]       idx_ff;
   logic [31:0]      data_ff;
   logic [4:0]       mode_ff;
   logic [3:0]       cond_ff;

   logic [31:0] base_ff;
   logic [31:0] vis_ff [16];
   logic [31:0] status_ff;
   logic [31:0] saved_irq_ff;   // only the IRQ bank's saved status is ever written

   logic [2:0]  ob_ff;
   logic [2:0]  nb_ff;
   logic [2:0]  slot_ff;
   logic [31:0] ret_ff;
   logic [31:0] old_status_ff;
   logic [31:0] rd_ff;
   logic        pass_ff;
   logic        taken_ff;
   logic        bad_ff;

   logic [31:0]            bank_mem [brmc_pkg::BANK_ENTRIES];
   logic [brmc_pkg::BANK_ENTRIES-1:0] bank_vld_ff;
   logic [31:0]            mem_rdata_ff;
   logic                   mem_rvld_ff;
   logic [AW-1:0]          mem_raddr;
   logic [AW-1:0]          mem_waddr;
   logic                   mem_we;
   logic [31:0]            swap_in;

   logic [3:0]  vis_raddr;
   logic [31:0] vis_rdata;
   logic [2:0]  out_bank;
   logic [2:0]  in_bank;
   logic [4:0]  sw_mode;
   logic [2:0]  sw_ob;
   logic [2:0]  sw_nb;
   logic        sw_fiq;

   assign busy = (state_ff != ST_IDLE);

   // One shared read port on the visible registers.
   always_comb begin
      if (state_ff == ST_SWAP_WR) begin
         vis_raddr = {1'b1, slot_ff};
      end else if (op_ff == brmc_pkg::OP_READ) begin
         vis_raddr = idx_ff;
      end else begin
         vis_raddr = 4'd15;
      end
      vis_rdata = vis_ff[vis_raddr];
   end

   // Slots r8..r12 use the user or FIQ bank; r13 and r14 use the mode's own bank.
   always_comb begin
      if (slot_ff < brmc_pkg::SLOT_R13) begin
         out_bank = (ob_ff == brmc_pkg::FIQ_BANK) ? brmc_pkg::FIQ_BANK : brmc_pkg::USR_BANK;
         in_bank  = (nb_ff == brmc_pkg::FIQ_BANK) ? brmc_pkg::FIQ_BANK : brmc_pkg::USR_BANK;
      end else begin
         out_bank = ob_ff;
         in_bank  = nb_ff;
      end
      mem_raddr = brmc_pkg::bank_base(in_bank) + AW'(slot_ff);
      mem_waddr = brmc_pkg::bank_base(out_bank) + AW'(slot_ff);
      mem_we    = (state_ff == ST_SWAP_WR);
      swap_in   = mem_rvld_ff ? mem_rdata_ff : 32'd0;
   end

   always_comb begin
      sw_mode = (op_ff == brmc_pkg::OP_IRQ) ? brmc_pkg::IRQ_MODE : mode_ff;
      sw_ob   = brmc_pkg::mode_bank(status_ff[4:0]);
      sw_nb   = brmc_pkg::mode_bank(sw_mode);
      sw_fiq  = (sw_ob == brmc_pkg::FIQ_BANK) || (sw_nb == brmc_pkg::FIQ_BANK);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bank_mem[mem_waddr] <= vis_rdata;
      end
      mem_rdata_ff <= bank_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         base_ff          <= '0;
         status_ff        <= brmc_pkg::STATUS_RESET;
         saved_irq_ff     <= '0;
         bank_vld_ff      <= '0;
         mem_rvld_ff      <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            vis_ff[i] <= '0;
         end
         op_ff            <= brmc_pkg::OP_READ;
         rsp_valid        <= 1'b0;
         rsp_cond_passed  <= 1'b0;
         rsp_irq_taken    <= 1'b0;
         rsp_bad_mode     <= 1'b0;
         rsp_status_word  <= brmc_pkg::STATUS_RESET;
      end else begin
         rsp_valid   <= (state_ff == ST_RESP);
         mem_rvld_ff <= bank_vld_ff[mem_raddr];
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
         if (mem_we) begin
            bank_vld_ff[mem_waddr] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= brmc_pkg::op_type'(req_op);
                  idx_ff   <= req_reg_index;
                  data_ff  <= req_data;
                  mode_ff  <= req_mode_value;
                  cond_ff  <= req_cond;
                  rd_ff    <= '0;
                  pass_ff  <= 1'b0;
                  taken_ff <= 1'b0;
                  bad_ff   <= 1'b0;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               case (op_ff)
                  brmc_pkg::OP_READ: begin
                     rd_ff    <= vis_rdata;
                     state_ff <= ST_RESP;
                  end
                  brmc_pkg::OP_WRITE: begin
                     vis_ff[idx_ff] <= data_ff;
                     state_ff       <= ST_RESP;
                  end
                  brmc_pkg::OP_STATUS: begin
                     status_ff <= {data_ff[31:5], status_ff[4:0]};
                     state_ff  <= ST_RESP;
                  end
                  brmc_pkg::OP_COND: begin
                     pass_ff  <= brmc_pkg::cond_holds(status_ff[31:28], cond_ff);
                     state_ff <= ST_RESP;
                  end
                  brmc_pkg::OP_SWITCH, brmc_pkg::OP_IRQ: begin
                     if (op_ff == brmc_pkg::OP_SWITCH && !brmc_pkg::mode_valid(mode_ff)) begin
                        bad_ff   <= 1'b1;
                        state_ff <= ST_RESP;
                     end else if (op_ff == brmc_pkg::OP_IRQ && status_ff[brmc_pkg::BIT_IMASK]) begin
                        taken_ff <= 1'b0;
                        state_ff <= ST_RESP;
                     end else begin
                        if (op_ff == brmc_pkg::OP_IRQ) begin
                           taken_ff      <= 1'b1;
                           old_status_ff <= status_ff;
                           ret_ff        <= status_ff[brmc_pkg::BIT_THUMB] ? vis_rdata
                                            : vis_rdata - brmc_pkg::ARM_RET_OFFSET;
                        end
                        status_ff[4:0] <= sw_mode;
                        ob_ff          <= sw_ob;
                        nb_ff          <= sw_nb;
                        slot_ff        <= sw_fiq ? 3'd0 : brmc_pkg::SLOT_R13;
                        if (sw_ob != sw_nb) begin
                           state_ff <= ST_SWAP_RD;
                        end else if (op_ff == brmc_pkg::OP_IRQ) begin
                           state_ff <= ST_IRQ_LR;
                        end else begin
                           state_ff <= ST_RESP;
                        end
                     end
                  end
                  default: begin
                     state_ff <= ST_RESP;
                  end
               endcase
            end
            ST_SWAP_RD: begin
               state_ff <= ST_SWAP_WR;
            end
            ST_SWAP_WR: begin
               // The outgoing value goes to the bank memory through mem_we.
               vis_ff[vis_raddr] <= swap_in;
               if (slot_ff == brmc_pkg::SLOT_R14) begin
                  state_ff <= (op_ff == brmc_pkg::OP_IRQ) ? ST_IRQ_LR : ST_RESP;
               end else begin
                  slot_ff  <= slot_ff + 3'd1;
                  state_ff <= ST_SWAP_RD;
               end
            end
            ST_IRQ_LR: begin
               vis_ff[14]   <= ret_ff;
               saved_irq_ff <= old_status_ff;
               status_ff[brmc_pkg::BIT_IMASK] <= 1'b1;
               status_ff[brmc_pkg::BIT_THUMB] <= 1'b0;
               state_ff     <= ST_IRQ_PC;
            end
            ST_IRQ_PC: begin
               vis_ff[15] <= base_ff + brmc_pkg::VEC_IRQ + brmc_pkg::PC_AHEAD;
               state_ff   <= ST_RESP;
            end
            ST_RESP: begin
               rsp_read_data    <= rd_ff;
               rsp_cond_passed  <= pass_ff;
               rsp_irq_taken    <= taken_ff;
               rsp_bad_mode     <= bad_ff;
               rsp_status_word  <= status_ff;
               rsp_saved_status <= (brmc_pkg::mode_bank(status_ff[4:0]) == brmc_pkg::IRQ_BANK)
                                   ? saved_irq_ff : 32'd0;
               state_ff         <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/brmc_checker.sv @@
// Port-level checks of the banked register and mode control block, bound to its top level.
module brmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_cond_passed,
   input logic        rsp_irq_taken,
   input logic        rsp_bad_mode,
   input logic [31:0] rsp_status_word
);

   // A taken request raises busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a request was taken");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_cond_passed, rsp_irq_taken, rsp_bad_mode}) <= 1))
      else $error("more than one result flag set");

   // A taken IRQ leaves the core in IRQ mode, masked and in ARM state.
   a_irq_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_irq_taken) |->
         (rsp_status_word[4:0] == brmc_pkg::IRQ_MODE
          && rsp_status_word[brmc_pkg::BIT_IMASK]
          && !rsp_status_word[brmc_pkg::BIT_THUMB]))
      else $error("IRQ taken without IRQ mode status");

endmodule

bind banked_register_mode_control brmc_checker u_brmc_checker (.*);
